>>> hw/rtl/mmc_pkg.sv
// Package for the Montgomery CIOS multiplier core.
// Channel payload types, register indexes, sequencer codes and limb width.
// No dependencies.
`default_nettype none
package mmc_pkg;

  localparam int LIMB_W = 64;

  // input transfer: one limb of a, b and n
  typedef struct packed {
    logic [4:0]        limb_index;
    logic [LIMB_W-1:0] a_limb;
    logic [LIMB_W-1:0] b_limb;
    logic [LIMB_W-1:0] n_limb;
    logic              last_limb;
  } mmc_in_t;

  // output transfer: one limb of the product
  typedef struct packed {
    logic [5:0]        result_index;
    logic [LIMB_W-1:0] result_limb;
    logic              last_result;
  } mmc_out_t;

  // control of the shared multiply-accumulate unit
  typedef struct packed {
    logic load;
    logic step;
  } mmc_mac_ctl_t;

  // register indexes (paddr[4:3])
  localparam logic [1:0] REG_LIMB_COUNT = 2'd0;
  localparam logic [1:0] REG_A_LENGTH   = 2'd1;
  localparam logic [1:0] REG_B_LENGTH   = 2'd2;
  localparam logic [1:0] REG_N0_INVERSE = 2'd3;

  // round phases
  localparam logic [1:0] PH_AB = 2'd0;
  localparam logic [1:0] PH_M  = 2'd1;
  localparam logic [1:0] PH_MN = 2'd2;

  // sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RSTRT = 4'd1;
  localparam logic [3:0] ST_RD    = 4'd2;
  localparam logic [3:0] ST_LD    = 4'd3;
  localparam logic [3:0] ST_MUL   = 4'd4;
  localparam logic [3:0] ST_WR    = 4'd5;
  localparam logic [3:0] ST_TOP   = 4'd6;
  localparam logic [3:0] ST_SH    = 4'd7;
  localparam logic [3:0] ST_SW    = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;
  localparam logic [3:0] ST_OL    = 4'd10;
  localparam logic [3:0] ST_OW    = 4'd11;

endpackage
`default_nettype wire

>>> hw/rtl/montgomery_multiply_cios_core.sv
// Montgomery multiplier, CIOS method over 64-bit limbs: top level and sequencer.
// Uses mmc_pkg and the shared multiply-accumulate unit mmc_mac.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------
//  in       | in_valid / in_stall   | in_data  (mmc_in_t)
//  out      | out_valid / out_stall | out_data (mmc_out_t)
//  cfg      | psel/penable/pwrite   | paddr[4:3] reg, pwdata/prdata
//
// After the last-marked load the block is busy: each round runs 2k+1 limb
// multiplies on the single 32x32 multiplier (read, load, four partial products,
// write back), plus round start, carry folds and the one-limb shift.
// The k+1 result limbs then leave one at a time, each held while out_stall is high.
// Reset (rst_n, synchronous) clears control state; limb stores are undefined.
// in_stall is high from the cycle after the last load until the top limb leaves.
`default_nettype none
module montgomery_multiply_cios_core
  import mmc_pkg::*;
#(
  parameter int MAX_LIMBS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire mmc_in_t           in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mmc_out_t               out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [63:0]       pwdata,
  output logic [63:0]            prdata,
  output logic                   pready
);

  localparam int AW = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;
  localparam logic [5:0] MAXK = 6'(MAX_LIMBS);

  // configuration registers
  logic [5:0]        limb_count_r, a_length_r, b_length_r;
  logic [LIMB_W-1:0] n0_inverse_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limb_count_r <= 6'd32;
      a_length_r   <= 6'd32;
      b_length_r   <= 6'd32;
      n0_inverse_r <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        REG_LIMB_COUNT: limb_count_r <= pwdata[5:0];
        REG_A_LENGTH:   a_length_r   <= pwdata[5:0];
        REG_B_LENGTH:   b_length_r   <= pwdata[5:0];
        REG_N0_INVERSE: n0_inverse_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_LIMB_COUNT: prdata = {58'd0, limb_count_r};
      REG_A_LENGTH:   prdata = {58'd0, a_length_r};
      REG_B_LENGTH:   prdata = {58'd0, b_length_r};
      REG_N0_INVERSE: prdata = n0_inverse_r;
      default:        prdata = '0;
    endcase
  end

  // sequencer registers
  logic [3:0]        state_r, state_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [5:0]        k_r, k_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [LIMB_W-1:0] c_r, c_nxt, m_r, m_nxt, top0_r, top0_nxt;
  logic              top1_r, top1_nxt;
  logic              out_valid_r, out_valid_nxt;
  mmc_out_t          out_r, out_nxt;

  // limb stores and accumulator memory
  logic [LIMB_W-1:0] a_mem   [MAX_LIMBS];
  logic [LIMB_W-1:0] b_mem   [MAX_LIMBS];
  logic [LIMB_W-1:0] n_mem   [MAX_LIMBS];
  logic [LIMB_W-1:0] acc_mem [MAX_LIMBS];
  logic [LIMB_W-1:0] a_q, b_q, n_q, acc_q;
  logic [5:0]        rd_idx;
  logic [5:0]        wr_idx;
  logic              acc_we;
  logic [5:0]        acc_wa;
  logic [LIMB_W-1:0] acc_wd;

  logic              in_xfer, out_xfer;
  logic [5:0]        k_clamp;

  // mac unit hookup
  mmc_mac_ctl_t        mac_ctl;
  logic [LIMB_W-1:0]   mac_x, mac_y, mac_t;
  logic [2*LIMB_W-1:0] mac_prod;
  logic                mac_last;
  logic [LIMB_W:0]     top_sum;

  assign in_xfer  = in_valid & ~in_stall;
  assign out_xfer = out_valid_r & ~out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign k_clamp = (limb_count_r == 6'd0) ? 6'd1 :
                   (limb_count_r > MAXK) ? MAXK : limb_count_r;
  assign top_sum = {1'b0, top0_r} + {1'b0, c_r};
  assign wr_idx  = {1'b0, in_data.limb_index};

  always_ff @(posedge clk) begin
    if (in_xfer && (wr_idx < MAXK)) begin
      a_mem[wr_idx[AW-1:0]] <= in_data.a_limb;
      b_mem[wr_idx[AW-1:0]] <= in_data.b_limb;
      n_mem[wr_idx[AW-1:0]] <= in_data.n_limb;
    end
    if (acc_we) begin
      acc_mem[acc_wa[AW-1:0]] <= acc_wd;
    end
    a_q   <= a_mem[rd_idx[AW-1:0]];
    n_q   <= n_mem[rd_idx[AW-1:0]];
    acc_q <= acc_mem[rd_idx[AW-1:0]];
    b_q   <= b_mem[i_r[AW-1:0]];
  end

  mmc_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .x     (mac_x),
    .y     (mac_y),
    .t     (mac_t),
    .c     (c_r),
    .prod  (mac_prod),
    .last  (mac_last)
  );

  // operand select for the mac load
  always_comb begin
    case (phase_r)
      PH_AB: begin
        mac_x = (j_r < a_length_r) ? a_q : '0;
        mac_y = (i_r < b_length_r) ? b_q : '0;
        mac_t = (i_r == 6'd0) ? '0 : acc_q;
      end
      PH_M: begin
        mac_x = acc_q;
        mac_y = n0_inverse_r;
        mac_t = '0;
      end
      default: begin
        mac_x = m_r;
        mac_y = n_q;
        mac_t = acc_q;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    c_nxt         = c_r;
    m_nxt         = m_r;
    top0_nxt      = top0_r;
    top1_nxt      = top1_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    rd_idx        = j_r;
    acc_we        = 1'b0;
    acc_wa        = j_r;
    acc_wd        = mac_prod[LIMB_W-1:0];
    mac_ctl       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_data.last_limb) begin
          k_nxt     = k_clamp;
          i_nxt     = 6'd0;
          top0_nxt  = '0;
          top1_nxt  = 1'b0;
          state_nxt = ST_RSTRT;
        end
      end
      // b[i] read settles
      ST_RSTRT: begin
        phase_nxt = PH_AB;
        j_nxt     = 6'd0;
        c_nxt     = '0;
        state_nxt = ST_RD;
      end
      ST_RD: state_nxt = ST_LD;
      ST_LD: begin
        mac_ctl.load = 1'b1;
        state_nxt    = ST_MUL;
      end
      ST_MUL: begin
        mac_ctl.step = 1'b1;
        if (mac_last) state_nxt = ST_WR;
      end
      ST_WR: begin
        if (phase_r == PH_M) begin
          m_nxt     = mac_prod[LIMB_W-1:0];
          c_nxt     = '0;
          phase_nxt = PH_MN;
          j_nxt     = 6'd0;
          state_nxt = ST_RD;
        end else begin
          acc_we = 1'b1;
          c_nxt  = mac_prod[2*LIMB_W-1:LIMB_W];
          if (j_r == k_r - 6'd1) begin
            state_nxt = ST_TOP;
          end else begin
            j_nxt     = j_r + 6'd1;
            state_nxt = ST_RD;
          end
        end
      end
      // fold the row carry into the two top limbs
      ST_TOP: begin
        top0_nxt = top_sum[LIMB_W-1:0];
        top1_nxt = top1_r ^ top_sum[LIMB_W];
        c_nxt    = '0;
        j_nxt    = 6'd0;
        if (phase_r == PH_AB) begin
          phase_nxt = PH_M;
          state_nxt = ST_RD;
        end else begin
          state_nxt = ST_SH;
        end
      end
      // shift down one limb
      ST_SH: begin
        rd_idx = j_r + 6'd1;
        if (j_r == k_r - 6'd1) begin
          acc_we   = 1'b1;
          acc_wd   = top0_r;
          top0_nxt = {{(LIMB_W-1){1'b0}}, top1_r};
          top1_nxt = 1'b0;
          if (i_r == k_r - 6'd1) begin
            j_nxt     = 6'd0;
            state_nxt = ST_OUT;
          end else begin
            i_nxt     = i_r + 6'd1;
            state_nxt = ST_RSTRT;
          end
        end else begin
          state_nxt = ST_SW;
        end
      end
      ST_SW: begin
        acc_we    = 1'b1;
        acc_wd    = acc_q;
        j_nxt     = j_r + 6'd1;
        state_nxt = ST_SH;
      end
      ST_OUT: state_nxt = ST_OL;
      ST_OL: begin
        out_nxt.result_index = j_r;
        out_nxt.result_limb  = (j_r == k_r) ? top0_r : acc_q;
        out_nxt.last_result  = (j_r == k_r);
        out_valid_nxt        = 1'b1;
        state_nxt            = ST_OW;
      end
      ST_OW: begin
        if (out_xfer) begin
          out_valid_nxt = 1'b0;
          if (j_r == k_r) begin
            state_nxt = ST_IDLE;
          end else begin
            j_nxt     = j_r + 6'd1;
            state_nxt = ST_OUT;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_AB;
      k_r         <= 6'd1;
      i_r         <= 6'd0;
      j_r         <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      k_r         <= k_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
    c_r    <= c_nxt;
    m_r    <= m_nxt;
    top0_r <= top0_nxt;
    top1_r <= top1_nxt;
    out_r  <= out_nxt;
  end

  // a result is only shown while waiting for its transfer
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_OW))
    else $error("out_valid outside output wait");

  // the top limb is flagged last and carries index k
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.last_result) |-> (out_r.result_index == k_r))
    else $error("last result index mismatch");

  // the last load starts the operation and blocks input
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_data.last_limb) |=> in_stall)
    else $error("input not stalled after last load");

  // round counter stays below k while busy computing
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (i_r < k_r))
    else $error("round counter out of range");

endmodule
`default_nettype wire

>>> hw/rtl/mmc_mac.sv
// Shared 64x64 multiply-accumulate unit: t + c + x*y into 128 bits.
// One 32x32 multiplier, one partial product per step. Uses mmc_pkg.
`default_nettype none
module mmc_mac
  import mmc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mmc_mac_ctl_t        ctl,
  input  wire logic [LIMB_W-1:0]   x,
  input  wire logic [LIMB_W-1:0]   y,
  input  wire logic [LIMB_W-1:0]   t,
  input  wire logic [LIMB_W-1:0]   c,
  output logic [2*LIMB_W-1:0]      prod,
  output logic                     last
);

  localparam int HW = LIMB_W / 2;

  logic [LIMB_W-1:0]   x_r, y_r;
  logic [2*LIMB_W-1:0] prod_r, prod_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic [HW-1:0]       xh, yh;
  logic [LIMB_W-1:0]   pp;
  logic [2*LIMB_W-1:0] pp_sh;

  // pick halves: low*low, low*high, high*low, high*high
  always_comb begin
    xh = cnt_r[1] ? x_r[LIMB_W-1:HW] : x_r[HW-1:0];
    yh = cnt_r[0] ? y_r[LIMB_W-1:HW] : y_r[HW-1:0];
    pp = xh * yh;
    case (cnt_r)
      2'd0:    pp_sh = {{LIMB_W{1'b0}}, pp};
      2'd3:    pp_sh = {pp, {LIMB_W{1'b0}}};
      default: pp_sh = {{HW{1'b0}}, pp, {HW{1'b0}}};
    endcase
  end

  always_comb begin
    prod_nxt = prod_r;
    cnt_nxt  = cnt_r;
    if (ctl.load) begin
      prod_nxt = {{LIMB_W{1'b0}}, t} + {{LIMB_W{1'b0}}, c};
      cnt_nxt  = 2'd0;
    end else if (ctl.step) begin
      prod_nxt = prod_r + pp_sh;
      cnt_nxt  = cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    prod_r <= prod_nxt;
    if (ctl.load) begin
      x_r <= x;
      y_r <= y;
    end
  end

  assign prod = prod_r;
  assign last = (cnt_r == 2'd3);

endmodule
`default_nettype wire
